@@ src/itp_pkg.sv @@
`timescale 1ns / 1ps

package itp_pkg;

	localparam int FID_W = 29;
	localparam int BYTE_W = 8;
	localparam int DATA_W = 64;
	localparam int NB_W = 4;
	localparam int LEN_W = 8;
	localparam int POS_W = 9;
	localparam int SHREG_W = 56;
	localparam int STORE_BYTES_DEF = 256;

	localparam int IN_TDATA_W = 96;
	localparam int OUT_TDATA_W = 112;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 29;

	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEP = 2'd2;

	localparam logic [3:0] PCI_SINGLE = 4'h0;
	localparam logic [3:0] PCI_FIRST = 4'h1;
	localparam logic [3:0] PCI_CONSEC = 4'h2;
	localparam logic [BYTE_W-1:0] FC_CTRL_BYTE = 8'h30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SF,
		ST_FF,
		ST_CF,
		ST_RD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_SF,
		SRC_FC,
		SRC_MSG
	} src_t;

	typedef struct packed {
		logic shift_en;
		logic [BYTE_W-1:0] din;
		logic load;
		logic kind;
		logic [FID_W-1:0] id;
		logic [NB_W-1:0] nbytes;
		logic [LEN_W-1:0] len;
		logic last;
	} emit_ctl_t;

endpackage

@@ src/itp_store.sv @@
`timescale 1ns / 1ps

module itp_store #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0] wr_data,
	input  logic rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0] rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/itp_out_stage.sv @@
`timescale 1ns / 1ps

module itp_out_stage (
	input  logic clk,
	input  logic arst_n,
	input  itp_pkg::emit_ctl_t ctl,
	output logic can_load,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_id, chunk_data, chunk_bytes, message_length, zero fill
	output logic [itp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// kind
	output logic m_axis_tuser,
	output logic m_axis_tlast
);

	import itp_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - FID_W - DATA_W - NB_W - LEN_W;

	logic [DATA_W-1:0] chunk_q;
	logic out_valid_q;
	logic [DATA_W-1:0] data_q;
	logic [FID_W-1:0] id_q;
	logic [NB_W-1:0] nbytes_q;
	logic [LEN_W-1:0] len_q;
	logic kind_q;
	logic last_q;

	assign can_load = !out_valid_q || m_axis_tready;

	// Bytes enter at the bottom, so after eight shifts the first byte sits on top.
	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			chunk_q <= {chunk_q[DATA_W-BYTE_W-1:0], ctl.din};
		end
		if (ctl.load) begin
			data_q <= chunk_q;
			id_q <= ctl.id;
			nbytes_q <= ctl.nbytes;
			len_q <= ctl.len;
			kind_q <= ctl.kind;
			last_q <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{PAD_W{1'b0}}, len_q, nbytes_q, data_q, id_q};
	assign m_axis_tuser = kind_q;
	assign m_axis_tlast = last_q;

endmodule

@@ src/isotp_frame_reassembler_core.sv @@
`timescale 1ns / 1ps

// ISO-TP receive reassembler. Each input beat is one CAN frame (id and eight
// bytes); single frames come out as one chunk, first frames are answered with
// a flow control beat, and consecutive frames are collected in a byte store
// until the announced length is reached, when the message leaves as chunks of
// up to eight bytes with tlast on the final one; a zero length gives no output.
// The data path moves one byte per cycle unless it waits to hand a beat over:
// a single frame or a first frame shifts eight bytes into the output stage and
// then hands its beat over, a consecutive frame writes seven bytes to the store,
// and a completing one makes, per chunk, eight store reads through the single
// registered read port, one drain and one hand-over. Output beats wait in an
// output register, so the next frame can be taken while one is still pending.
module isotp_frame_reassembler_core #(
	parameter int STORE_BYTES = itp_pkg::STORE_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [itp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [itp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// frame_id, byte_0 .. byte_7, zero fill
	input  logic [itp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_id, chunk_data, chunk_bytes, message_length, zero fill
	output logic [itp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// kind
	output logic m_axis_tuser,
	output logic m_axis_tlast
);

	import itp_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [POS_W-1:0] STORE_LIM = POS_W'(STORE_BYTES);

	state_t state_q, state_nx;
	src_t src_q;
	logic [3:0] step_q;
	logic [SHREG_W-1:0] shreg_q;
	logic [FID_W-1:0] fid_q;
	logic [3:0] sf_len_q;
	logic [LEN_W-1:0] target_q;
	logic [POS_W-1:0] count_q;
	logic in_prog_q;
	logic [POS_W-1:0] rd_pos_q;
	logic [POS_W-1:0] chunk_pos_q;
	logic rd_ok_s1;
	logic [FID_W-1:0] flow_id_q;
	logic [BYTE_W-1:0] blk_size_q;
	logic [BYTE_W-1:0] min_sep_q;

	logic [BYTE_W-1:0] in_byte [8];
	logic [FID_W-1:0] in_fid;
	logic [3:0] in_pci;
	logic [3:0] in_sf_len;
	logic accept;
	logic sf_ok;
	logic [POS_W-1:0] target9;
	logic cf_complete;
	logic rd_ok;
	logic last_chunk;
	logic [POS_W-1:0] remain;
	logic can_load;
	logic wr_en;
	logic rd_en;
	logic [BYTE_W-1:0] rd_data;
	emit_ctl_t ctl;

	always_comb begin
		in_fid = s_axis_tdata[FID_W-1:0];
		for (int k = 0; k < 8; k++) begin
			in_byte[k] = s_axis_tdata[FID_W + BYTE_W*k +: BYTE_W];
		end
	end

	assign in_pci = in_byte[0][7:4];
	assign in_sf_len = in_byte[0][3:0];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign sf_ok = (in_sf_len != 4'd0) && (in_sf_len < 4'd8);
	assign target9 = {1'b0, target_q};
	assign cf_complete = (count_q + POS_W'(1)) >= target9;
	assign rd_ok = (rd_pos_q < target9) && (rd_pos_q < STORE_LIM);
	assign last_chunk = (chunk_pos_q + POS_W'(8)) >= target9;
	assign remain = target9 - chunk_pos_q;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_pci)
						PCI_SINGLE: state_nx = sf_ok ? ST_SF : ST_IDLE;
						PCI_FIRST: state_nx = ST_FF;
						PCI_CONSEC: state_nx = in_prog_q ? ST_CF : ST_IDLE;
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_SF, ST_FF: begin
				if (step_q == 4'd7) begin
					state_nx = ST_EMIT;
				end
			end
			ST_CF: begin
				if (step_q == 4'd6) begin
					// A zero length closes the message without any output.
					state_nx = (cf_complete && target_q != '0) ? ST_RD : ST_IDLE;
				end
			end
			ST_RD: begin
				if (step_q == 4'd8) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (can_load) begin
					state_nx = (src_q == SRC_MSG && !last_chunk) ? ST_RD : ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		wr_en = 1'b0;
		rd_en = 1'b0;
		ctl = '0;
		unique case (state_q)
			ST_SF: begin
				ctl.shift_en = 1'b1;
				ctl.din = (step_q < sf_len_q) ? shreg_q[SHREG_W-1 -: BYTE_W] : '0;
			end
			ST_FF: begin
				wr_en = (step_q < 4'd6) && (count_q < STORE_LIM);
				ctl.shift_en = 1'b1;
				case (step_q)
					4'd0: ctl.din = FC_CTRL_BYTE;
					4'd1: ctl.din = blk_size_q;
					4'd2: ctl.din = min_sep_q;
					default: ctl.din = '0;
				endcase
			end
			ST_CF: begin
				wr_en = (count_q < STORE_LIM);
			end
			ST_RD: begin
				rd_en = (step_q < 4'd8) && rd_ok;
				ctl.shift_en = (step_q != 4'd0);
				ctl.din = rd_ok_s1 ? rd_data : '0;
			end
			ST_EMIT: begin
				ctl.load = can_load;
			end
			default: begin
			end
		endcase

		unique case (src_q)
			SRC_SF: begin
				ctl.kind = 1'b0;
				ctl.id = fid_q;
				ctl.nbytes = sf_len_q;
				ctl.len = {4'd0, sf_len_q};
				ctl.last = 1'b1;
			end
			SRC_FC: begin
				ctl.kind = 1'b1;
				ctl.id = flow_id_q;
				ctl.nbytes = 4'd8;
				ctl.len = target_q;
				ctl.last = 1'b1;
			end
			default: begin
				ctl.kind = 1'b0;
				ctl.id = fid_q;
				ctl.nbytes = last_chunk ? remain[NB_W-1:0] : 4'd8;
				ctl.len = target_q;
				ctl.last = last_chunk;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			src_q <= SRC_SF;
			step_q <= '0;
			target_q <= '0;
			count_q <= '0;
			in_prog_q <= 1'b0;
			rd_pos_q <= '0;
			chunk_pos_q <= '0;
			rd_ok_s1 <= 1'b0;
			flow_id_q <= '0;
			blk_size_q <= '0;
			min_sep_q <= '0;
		end else begin
			state_q <= state_nx;
			rd_ok_s1 <= rd_en;

			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_FLOW_ID: flow_id_q <= cfg_data;
					CFG_BLOCK_SIZE: blk_size_q <= cfg_data[BYTE_W-1:0];
					CFG_MIN_SEP: min_sep_q <= cfg_data[BYTE_W-1:0];
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						unique case (in_pci)
							PCI_SINGLE: src_q <= SRC_SF;
							PCI_FIRST: begin
								src_q <= SRC_FC;
								target_q <= in_byte[1];
								count_q <= '0;
								in_prog_q <= 1'b1;
							end
							default: src_q <= SRC_MSG;
						endcase
					end
				end
				ST_SF: begin
					step_q <= step_q + 4'd1;
				end
				ST_FF: begin
					step_q <= step_q + 4'd1;
					if (step_q < 4'd6) begin
						count_q <= count_q + POS_W'(1);
					end
				end
				ST_CF: begin
					step_q <= step_q + 4'd1;
					count_q <= count_q + POS_W'(1);
					if (step_q == 4'd6 && cf_complete) begin
						in_prog_q <= 1'b0;
						rd_pos_q <= '0;
						chunk_pos_q <= '0;
						step_q <= '0;
					end
				end
				ST_RD: begin
					step_q <= step_q + 4'd1;
					if (step_q < 4'd8) begin
						rd_pos_q <= rd_pos_q + POS_W'(1);
					end
				end
				ST_EMIT: begin
					if (can_load && src_q == SRC_MSG && !last_chunk) begin
						chunk_pos_q <= chunk_pos_q + POS_W'(8);
						step_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Frame payload: the data bytes leave through the top of a byte shift register.
	always_ff @(posedge clk) begin
		if (accept) begin
			fid_q <= in_fid;
			sf_len_q <= in_sf_len;
			if (in_pci == PCI_FIRST) begin
				shreg_q <= {in_byte[2], in_byte[3], in_byte[4], in_byte[5],
					in_byte[6], in_byte[7], {BYTE_W{1'b0}}};
			end else begin
				shreg_q <= {in_byte[1], in_byte[2], in_byte[3], in_byte[4],
					in_byte[5], in_byte[6], in_byte[7]};
			end
		end else if (state_q == ST_SF || state_q == ST_FF || state_q == ST_CF) begin
			shreg_q <= {shreg_q[SHREG_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
	end

	itp_store #(
		.DEPTH(STORE_BYTES),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(shreg_q[SHREG_W-1 -: BYTE_W]),
		.rd_en(rd_en),
		.rd_addr(rd_pos_q[AW-1:0]),
		.rd_data(rd_data)
	);

	itp_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.can_load(can_load),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import itp_pkg::*;

	localparam int STORE_SIZE = STORE_BYTES_DEF;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 400;
	localparam int LONG_HOLD = 600;
	localparam int PRINT_CAP = 100;

	localparam logic [3:0] PCI_FLOW = 4'h3;
	localparam logic KIND_CHUNK = 1'b0;
	localparam logic KIND_FLOW = 1'b1;

	typedef struct packed {
		logic kind;
		logic [FID_W-1:0] id;
		logic [DATA_W-1:0] data;
		logic [NB_W-1:0] nbytes;
		logic [LEN_W-1:0] len;
		logic last;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	isotp_frame_reassembler_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Frames waiting to be sent, and beats the reassembler is expected to produce.
	logic [IN_TDATA_W-1:0] pending_frames[$];
	out_beat_t awaited_beats[$];

	// Shadow of the configuration registers.
	logic [FID_W-1:0] fc_id_cfg = '0;
	logic [7:0] fc_block_cfg = '0;
	logic [7:0] fc_sep_cfg = '0;

	// Shadow of the reassembly state.
	logic [7:0] msg_target = '0;
	logic [8:0] msg_count = '0;
	logic msg_open = 1'b0;
	logic [7:0] payload [STORE_SIZE];

	int err_count = 0;
	int frames_queued = 0;
	int frames_sent = 0;
	int beats_checked = 0;
	int msgs_done = 0;
	int send_gap = 0;
	int rcv_gap = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int idle_cycles = 0;
	logic calm = 1'b0;

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic out_beat_t make_beat(input logic kind, input logic [FID_W-1:0] id,
			input logic [DATA_W-1:0] data, input int nbytes, input int len, input logic last);
		out_beat_t r;
		r.kind = kind;
		r.id = id;
		r.data = data;
		r.nbytes = NB_W'(nbytes);
		r.len = LEN_W'(len);
		r.last = last;
		return r;
	endfunction

	// Works out what one accepted CAN frame produces and updates the shadow state.
	task automatic reassemble_frame(input logic [IN_TDATA_W-1:0] beat);
		logic [FID_W-1:0] fid;
		logic [7:0] b [8];
		logic [DATA_W-1:0] data;
		int n, pos, i;
		fid = beat[FID_W-1:0];
		for (i = 0; i < 8; i++)
			b[i] = beat[FID_W + 8*i +: 8];
		case (b[0][7:4])
			PCI_SINGLE: begin
				n = int'(b[0][3:0]);
				if (n >= 1 && n <= 7) begin
					data = '0;
					for (i = 0; i < n; i++)
						data[DATA_W-1 - 8*i -: 8] = b[1+i];
					awaited_beats.push_back(make_beat(KIND_CHUNK, fid, data, n, n, 1'b1));
				end
			end
			PCI_FIRST: begin
				msg_target = b[1];
				msg_count = 9'd6;
				msg_open = 1'b1;
				for (i = 0; i < 6; i++)
					payload[i] = b[2+i];
				data = {FC_CTRL_BYTE, fc_block_cfg, fc_sep_cfg, 40'h0};
				awaited_beats.push_back(make_beat(KIND_FLOW, fc_id_cfg, data, 8,
					int'(msg_target), 1'b1));
			end
			PCI_CONSEC: begin
				if (msg_open) begin
					// Bytes past the end of the store are dropped.
					for (i = 0; i < 7; i++)
						if (int'(msg_count) + i < STORE_SIZE)
							payload[int'(msg_count) + i] = b[1+i];
					msg_count = msg_count + 9'd7;
					if (msg_count >= msg_target) begin
						msg_open = 1'b0;
						msgs_done++;
						for (pos = 0; pos < msg_target; pos += 8) begin
							n = int'(msg_target) - pos;
							if (n > 8)
								n = 8;
							data = '0;
							for (i = 0; i < n; i++)
								data[DATA_W-1 - 8*i -: 8] = payload[pos+i];
							awaited_beats.push_back(make_beat(KIND_CHUNK, fid, data, n,
								int'(msg_target), pos + 8 >= msg_target));
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic logic [FID_W-1:0] rnd_fid();
		return FID_W'($urandom);
	endfunction

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [3:0] rnd_nib();
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [47:0] rnd_tail();
		return 48'({$urandom, $urandom});
	endfunction

	// tail holds byte_2 in its low bits up to byte_7 in its high bits.
	task automatic queue_frame(input logic [FID_W-1:0] fid, input logic [7:0] b0,
			input logic [7:0] b1, input logic [47:0] tail);
		pending_frames.push_back({3'b000, tail, b1, b0, fid});
		frames_queued++;
	endtask

	// A first frame followed by the consecutive frames it needs, or fewer when broken.
	task automatic queue_message(input bit broken);
		int len, ncf, k;
		logic [3:0] seq, sf_len;
		if ($urandom_range(0, 24) == 0)
			len = $urandom_range(200, 255);
		else
			len = $urandom_range(0, 40);
		ncf = (len <= 6) ? 1 : (len - 6 + 6) / 7;
		if (broken)
			ncf = $urandom_range(0, ncf - 1);
		queue_frame(rnd_fid(), {PCI_FIRST, rnd_nib()}, len[7:0], rnd_tail());
		for (k = 0; k < ncf; k++) begin
			if ($urandom_range(0, 11) == 0) begin
				sf_len = 4'($urandom_range(1, 7));
				queue_frame(rnd_fid(), {PCI_SINGLE, sf_len}, rnd_byte(), rnd_tail());
			end
			seq = 4'(k + 1);
			queue_frame(rnd_fid(), {PCI_CONSEC, seq}, rnd_byte(), rnd_tail());
		end
	endtask

	task automatic queue_random(input int count);
		int goal, pick;
		goal = frames_queued + count;
		while (frames_queued < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				queue_message(1'b0);
			else if (pick < 72)
				queue_message(1'b1);
			else if (pick < 87)
				queue_frame(rnd_fid(), {PCI_SINGLE, rnd_nib()}, rnd_byte(), rnd_tail());
			else
				queue_frame(rnd_fid(), rnd_byte(), rnd_byte(), rnd_tail());
		end
	endtask

	task automatic write_config(input logic [FID_W-1:0] id, input logic [7:0] bs,
			input logic [7:0] sep);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_FLOW_ID;
		cfg_data <= id;
		fc_id_cfg = id;
		@(posedge clk);
		cfg_index <= CFG_BLOCK_SIZE;
		cfg_data <= {21'h0, bs};
		fc_block_cfg = bs;
		@(posedge clk);
		cfg_index <= CFG_MIN_SEP;
		cfg_data <= {21'h0, sep};
		fc_sep_cfg = sep;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Waits until all frames are sent and all expected beats are in, then settles.
	task automatic wait_drained();
		while (pending_frames.size() != 0 || s_axis_tvalid || awaited_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Frame driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				reassemble_frame(s_axis_tdata);
				frames_sent++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// Beat still offered; hold it.
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_frames.size() != 0) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 4);
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata <= pending_frames.pop_front();
					s_axis_tvalid <= 1'b1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls and one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rcv_gap <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rcv_gap > 0) begin
			rcv_gap <= rcv_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			rcv_gap <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_checked++;
			if (awaited_beats.size() == 0) begin
				flag_error($sformatf("result beat %0h with nothing expected", m_axis_tdata));
			end else begin
				want = awaited_beats.pop_front();
				check_field("kind", DATA_W'(m_axis_tuser), DATA_W'(want.kind));
				check_field("out_id", DATA_W'(m_axis_tdata[FID_W-1:0]), DATA_W'(want.id));
				check_field("chunk_data", m_axis_tdata[FID_W +: DATA_W], want.data);
				check_field("chunk_bytes", DATA_W'(m_axis_tdata[FID_W+DATA_W +: NB_W]),
					DATA_W'(want.nbytes));
				check_field("message_length",
					DATA_W'(m_axis_tdata[FID_W+DATA_W+NB_W +: LEN_W]), DATA_W'(want.len));
				check_field("last", DATA_W'(m_axis_tlast), DATA_W'(want.last));
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(29'h1FFFFFFF, 8'hFF, 8'hFF);
		// Single frames at both length extremes, then the dropped lengths.
		queue_frame(29'h0, {PCI_SINGLE, 4'h1}, 8'h00, 48'h0);
		queue_frame(29'h1FFFFFFF, {PCI_SINGLE, 4'h7}, 8'hFF, 48'hFFFF_FFFF_FFFF);
		queue_frame(rnd_fid(), {PCI_SINGLE, 4'h0}, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), {PCI_SINGLE, 4'h8}, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), {PCI_SINGLE, 4'hF}, rnd_byte(), rnd_tail());
		// A zero total length closes silently on the next consecutive frame.
		queue_frame(rnd_fid(), {PCI_FIRST, 4'h0}, 8'h00, rnd_tail());
		queue_frame(rnd_fid(), {PCI_CONSEC, 4'h1}, rnd_byte(), rnd_tail());
		// Consecutive frame with nothing open, flow control and unknown types.
		queue_frame(rnd_fid(), {PCI_CONSEC, 4'hF}, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), {PCI_FLOW, 4'h0}, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), 8'h4A, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF);
		// Short length completes on the first consecutive frame.
		queue_frame(rnd_fid(), {PCI_FIRST, 4'hF}, 8'd3, rnd_tail());
		queue_frame(rnd_fid(), {PCI_CONSEC, 4'h1}, rnd_byte(), rnd_tail());
		// Single frame inside an open message, then a first frame abandoning it.
		queue_frame(rnd_fid(), {PCI_FIRST, 4'h0}, 8'd20, rnd_tail());
		queue_frame(rnd_fid(), {PCI_SINGLE, 4'h5}, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), {PCI_FIRST, 4'h0}, 8'd13, rnd_tail());
		queue_frame(rnd_fid(), {PCI_CONSEC, 4'h1}, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), {PCI_CONSEC, 4'h2}, rnd_byte(), rnd_tail());
		// Chunk boundary: exactly eight bytes, then nine.
		queue_frame(rnd_fid(), {PCI_FIRST, 4'h0}, 8'd8, rnd_tail());
		queue_frame(rnd_fid(), {PCI_CONSEC, 4'h1}, rnd_byte(), rnd_tail());
		queue_frame(rnd_fid(), {PCI_FIRST, 4'h0}, 8'd9, rnd_tail());
		queue_frame(rnd_fid(), {PCI_CONSEC, 4'h1}, rnd_byte(), rnd_tail());
		wait_drained();

		write_config(29'h0, 8'h00, 8'h00);
		queue_random(130);
		// Stall the output while frames keep coming so the input backs up.
		while (pending_frames.size() >= 80)
			@(posedge clk);
		@(posedge clk);
		hold_req <= hold_req + 1;
		wait_drained();

		write_config(rnd_fid(), rnd_byte(), rnd_byte());
		queue_random(130);
		wait_drained();

		write_config(rnd_fid(), rnd_byte(), rnd_byte());
		queue_random(100);
		wait_drained();

		@(posedge clk);
		calm <= 1'b1;
		write_config(29'h1FFFFFFF, 8'h00, 8'hFF);
		queue_random(100);
		wait_drained();

		if (awaited_beats.size() != 0)
			flag_error($sformatf("%0d expected beats never arrived", awaited_beats.size()));
		$display("summary: %0d frames sent, %0d result beats checked, %0d messages reassembled",
			frames_sent, beats_checked, msgs_done);
		$display("summary: five register settings, %0d mismatches", err_count);
		if (err_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
src/itp_pkg.sv
src/itp_store.sv
src/itp_out_stage.sv
src/isotp_frame_reassembler_core.sv
bench/testbench.sv
